// ===== rtl/ipsp_pkg.sv =====
// Shared types and codes for the inline palette spec parser.
// No dependencies; used by every module in rtl/.
package ipsp_pkg;

	localparam int unsigned MAX_PALETTES = 256;

	localparam logic [1:0] KIND_COLOR = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_MISSING_COLOR = 3'd0;
	localparam logic [2:0] ERR_DIGIT_COUNT   = 3'd1;
	localparam logic [2:0] ERR_OVER_FOUR     = 3'd2;
	localparam logic [2:0] ERR_BAD_SEP       = 3'd3;
	localparam logic [2:0] ERR_EXPECT_HASH   = 3'd4;
	localparam logic [2:0] ERR_TOO_MANY_PAL  = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] palette_index;
		logic [1:0] slot;
		logic       is_none;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] palette_count;
		logic [2:0] error_code;
		logic       last_of_run;
	} result_t;

	// results produced by one accepted input word (0, 1 or 2)
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t make_color(input logic [7:0] pal, input logic [2:0] slot,
			input logic nn, input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		result_t res;
		res = '0;
		res.kind = KIND_COLOR;
		res.palette_index = pal;
		res.slot = slot[1:0];
		res.is_none = nn;
		res.red = r;
		res.green = g;
		res.blue = b;
		return res;
	endfunction

	function automatic result_t make_done(input logic [8:0] count);
		result_t res;
		res = '0;
		res.kind = KIND_DONE;
		res.palette_count = count;
		return res;
	endfunction

	function automatic result_t make_error(input logic [2:0] code);
		result_t res;
		res = '0;
		res.kind = KIND_ERROR;
		res.error_code = code;
		return res;
	endfunction

endpackage

// ===== rtl/ipsp_core.sv =====
// Parser state machine: consumes one character word per accepted cycle and
// produces up to two results. Depends on ipsp_pkg.
module ipsp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     char_code,
	input  logic           end_of_text,
	output ipsp_pkg::push_t push
);

	localparam logic [2:0] PH_LEAD        = 3'd0;
	localparam logic [2:0] PH_START       = 3'd1;
	localparam logic [2:0] PH_NONE        = 3'd2;
	localparam logic [2:0] PH_HEX         = 3'd3;
	localparam logic [2:0] PH_AFTER_COLOR = 3'd4;
	localparam logic [2:0] PH_AFTER_COMMA = 3'd5;
	localparam logic [2:0] PH_AFTER_SEMI  = 3'd6;
	localparam logic [2:0] PH_DRAIN       = 3'd7;

	localparam logic [8:0] PAL_LIMIT = 9'(ipsp_pkg::MAX_PALETTES);

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  none_q, none_d;
	logic [2:0]  dcnt_q, dcnt_d;
	logic [23:0] dbuf_q, dbuf_d;
	logic [2:0]  slot_q, slot_d;
	logic [7:0]  pal_q, pal_d;

	logic        is_hex;
	logic [3:0]  hexv;
	logic [7:0]  lc;
	logic        blank, semi;
	logic [7:0]  none_char;

	// separator handling, evaluated as if the phase were sep_phase
	logic [2:0]  sep_phase;
	logic        sep_emit;
	ipsp_pkg::result_t sep_res;
	logic        sep_clear;
	logic [2:0]  sep_phase_d;
	logic [2:0]  sep_slot_d;
	logic [7:0]  sep_pal_d;

	ipsp_pkg::result_t col_res;
	logic        clear;

	always_comb begin
		is_hex = 1'b1;
		hexv = 4'd0;
		if (char_code >= "0" && char_code <= "9") begin
			hexv = 4'(char_code - "0");
		end else if (char_code >= "A" && char_code <= "F") begin
			hexv = 4'(char_code - "A" + 8'd10);
		end else if (char_code >= "a" && char_code <= "f") begin
			hexv = 4'(char_code - "a" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
		lc = char_code | 8'h20;
		blank = (char_code == " ") || (char_code == 8'h09);
		semi = (char_code == ";") || (char_code == ":");
		case (none_q)
			2'd1:    none_char = "o";
			2'd2:    none_char = "n";
			2'd3:    none_char = "e";
			default: none_char = "n";
		endcase
	end

	always_comb begin
		sep_phase = (phase_q == PH_HEX) ? PH_AFTER_COLOR : phase_q;
		sep_emit = 1'b0;
		sep_res = '0;
		sep_clear = 1'b0;
		sep_phase_d = sep_phase;
		sep_slot_d = slot_q;
		sep_pal_d = pal_q;
		if (end_of_text) begin
			sep_emit = 1'b1;
			sep_res = ipsp_pkg::make_done({1'b0, pal_q} + 9'd1);
			sep_clear = 1'b1;
		end else if (!blank) begin
			case (sep_phase)
				PH_AFTER_COLOR: begin
					if (char_code == ",") begin
						sep_slot_d = slot_q + 3'd1;
						sep_phase_d = PH_AFTER_COMMA;
					end else if (semi) begin
						sep_slot_d = 3'd0;
						sep_phase_d = PH_AFTER_SEMI;
					end else begin
						sep_emit = 1'b1;
						sep_res = ipsp_pkg::make_error(ipsp_pkg::ERR_BAD_SEP);
						sep_phase_d = PH_DRAIN;
					end
				end
				PH_AFTER_COMMA: begin
					if (semi) begin
						sep_slot_d = 3'd0;
						sep_phase_d = PH_AFTER_SEMI;
					end else if (slot_q >= 3'd4) begin
						sep_emit = 1'b1;
						sep_res = ipsp_pkg::make_error(ipsp_pkg::ERR_OVER_FOUR);
						sep_phase_d = PH_DRAIN;
					end else if (char_code == "#") begin
						sep_phase_d = PH_START;
					end else begin
						sep_emit = 1'b1;
						sep_res = ipsp_pkg::make_error(ipsp_pkg::ERR_EXPECT_HASH);
						sep_phase_d = PH_DRAIN;
					end
				end
				default: begin
					if ({1'b0, pal_q} + 9'd1 >= PAL_LIMIT) begin
						sep_emit = 1'b1;
						sep_res = ipsp_pkg::make_error(ipsp_pkg::ERR_TOO_MANY_PAL);
						sep_phase_d = PH_DRAIN;
					end else begin
						sep_pal_d = pal_q + 8'd1;
						sep_slot_d = 3'd0;
						if (char_code == "#") begin
							sep_phase_d = PH_START;
						end else begin
							sep_emit = 1'b1;
							sep_res = ipsp_pkg::make_error(ipsp_pkg::ERR_EXPECT_HASH);
							sep_phase_d = PH_DRAIN;
						end
					end
				end
			endcase
		end
	end

	// color from the finished hex run; three digits replicate each nibble
	always_comb begin
		if (dcnt_q == 3'd3) begin
			col_res = ipsp_pkg::make_color(pal_q, slot_q, 1'b0, {2{dbuf_q[11:8]}},
				{2{dbuf_q[7:4]}}, {2{dbuf_q[3:0]}});
		end else begin
			col_res = ipsp_pkg::make_color(pal_q, slot_q, 1'b0, dbuf_q[23:16],
				dbuf_q[15:8], dbuf_q[7:0]);
		end
	end

	always_comb begin
		phase_d = phase_q;
		none_d = none_q;
		dcnt_d = dcnt_q;
		dbuf_d = dbuf_q;
		slot_d = slot_q;
		pal_d = pal_q;
		clear = 1'b0;
		push = '0;
		case (phase_q)
			PH_LEAD: begin
				if (end_of_text) begin
					push.num = 2'd1;
					push.r0 = ipsp_pkg::make_error(ipsp_pkg::ERR_MISSING_COLOR);
					clear = 1'b1;
				end else begin
					phase_d = PH_START;
				end
			end
			PH_START: begin
				if (end_of_text) begin
					push.num = 2'd1;
					push.r0 = ipsp_pkg::make_error(ipsp_pkg::ERR_MISSING_COLOR);
					clear = 1'b1;
				end else if (lc == "n") begin
					none_d = 2'd1;
					phase_d = PH_NONE;
				end else if (is_hex) begin
					dcnt_d = 3'd1;
					dbuf_d = {20'd0, hexv};
					phase_d = PH_HEX;
				end else begin
					push.num = 2'd1;
					push.r0 = ipsp_pkg::make_error(ipsp_pkg::ERR_MISSING_COLOR);
					phase_d = PH_DRAIN;
				end
			end
			PH_NONE: begin
				if (!end_of_text && lc == none_char) begin
					none_d = none_q + 2'd1;
					if (none_q == 2'd3) begin
						push.num = 2'd1;
						push.r0 = ipsp_pkg::make_color(pal_q, slot_q, 1'b1, 8'd0, 8'd0, 8'd0);
						phase_d = PH_AFTER_COLOR;
					end
				end else begin
					none_d = 2'd0;
					push.num = 2'd1;
					push.r0 = ipsp_pkg::make_error(ipsp_pkg::ERR_MISSING_COLOR);
					clear = end_of_text;
					phase_d = PH_DRAIN;
				end
			end
			PH_HEX: begin
				if (!end_of_text && is_hex) begin
					dbuf_d = {dbuf_q[19:0], hexv};
					dcnt_d = dcnt_q + 3'd1;
					if (dcnt_q == 3'd6) begin
						push.num = 2'd1;
						push.r0 = ipsp_pkg::make_error(ipsp_pkg::ERR_DIGIT_COUNT);
						phase_d = PH_DRAIN;
					end
				end else if (dcnt_q == 3'd3 || dcnt_q == 3'd6) begin
					push.num = sep_emit ? 2'd2 : 2'd1;
					push.r0 = col_res;
					push.r1 = sep_res;
					dcnt_d = 3'd0;
					dbuf_d = 24'd0;
					phase_d = sep_phase_d;
					slot_d = sep_slot_d;
					pal_d = sep_pal_d;
					clear = sep_clear;
				end else begin
					push.num = 2'd1;
					push.r0 = ipsp_pkg::make_error(ipsp_pkg::ERR_DIGIT_COUNT);
					clear = end_of_text;
					phase_d = PH_DRAIN;
				end
			end
			PH_AFTER_COLOR, PH_AFTER_COMMA, PH_AFTER_SEMI: begin
				push.num = sep_emit ? 2'd1 : 2'd0;
				push.r0 = sep_res;
				phase_d = sep_phase_d;
				slot_d = sep_slot_d;
				pal_d = sep_pal_d;
				clear = sep_clear;
			end
			default: begin
				clear = end_of_text;
			end
		endcase
		if (push.num == 2'd2) begin
			push.r1.last_of_run = 1'b1;
		end else if (push.num == 2'd1) begin
			push.r0.last_of_run = 1'b1;
		end
		if (!take) begin
			push.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			none_q <= 2'd0;
			dcnt_q <= 3'd0;
			dbuf_q <= 24'd0;
			slot_q <= 3'd0;
			pal_q <= 8'd0;
		end else if (take) begin
			if (clear) begin
				phase_q <= PH_LEAD;
				none_q <= 2'd0;
				dcnt_q <= 3'd0;
				dbuf_q <= 24'd0;
				slot_q <= 3'd0;
				pal_q <= 8'd0;
			end else begin
				phase_q <= phase_d;
				none_q <= none_d;
				dcnt_q <= dcnt_d;
				dbuf_q <= dbuf_d;
				slot_q <= slot_d;
				pal_q <= pal_d;
			end
		end
	end

endmodule

// ===== rtl/ipsp_result_queue.sv =====
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on ipsp_pkg.
module ipsp_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  ipsp_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output ipsp_pkg::result_t head
);

	ipsp_pkg::result_t mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign room = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign pop = out_valid && out_ready;
	assign head = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q <= wr_q + push.num;
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push.num} - {2'd0, pop};
		end
	end

endmodule

// ===== rtl/inline_palette_spec_parser_top.sv =====
// Top level of the inline palette spec parser.
// Depends on ipsp_pkg, ipsp_core and ipsp_result_queue.
//
// Input channel (in_valid/in_ready): one word per character of the spec,
// char_code plus end_of_text; a word with end_of_text set closes the text.
// Output channel (out_valid/out_ready): result words - color entries, then
// one done word with palette_count or one error word with error_code.
// last_of_run marks the final result caused by an input word.
// Throughput: one input word per cycle while in_ready is high. A word that
// yields two results (color plus done/error) fills two queue entries; the parser keeps
// accepting while the four-entry result queue has room for two results.
// Results are registered into the queue and presented in order behind earlier ones.
// Reset: the parser returns to its lead phase (first character taken
// unchecked) and the queue empties. When the receiver stalls, results
// queue up and in_ready drops once fewer than two entries remain free.
module inline_palette_spec_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] palette_index,
	output logic [1:0] slot,
	output logic       is_none,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [8:0] palette_count,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	ipsp_pkg::push_t   push;
	ipsp_pkg::result_t head;
	logic              room;

	assign in_ready = room;

	ipsp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_valid && room),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.push        (push)
	);

	ipsp_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind = head.kind;
	assign palette_index = head.palette_index;
	assign slot = head.slot;
	assign is_none = head.is_none;
	assign red = head.red;
	assign green = head.green;
	assign blue = head.blue;
	assign palette_count = head.palette_count;
	assign error_code = head.error_code;
	assign last_of_run = head.last_of_run;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for inline_palette_spec_parser_top: feeds palette spec text one
// character word at a time and checks every result word against a built-in parser model.
// Depends on ipsp_pkg and the RTL under rtl/.
module testbench;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_WORDS = 80;
	localparam int unsigned HOLD_CYCLES  = 300;

	localparam logic [7:0]  CH_HASH   = "#";
	localparam logic [7:0]  CH_SPACE  = " ";
	localparam logic [7:0]  CH_TAB    = 8'h09;
	localparam logic [31:0] NONE_WORD = "none";

	localparam logic [2:0] SC_LEAD        = 3'd0;
	localparam logic [2:0] SC_OPEN        = 3'd1;
	localparam logic [2:0] SC_NONE        = 3'd2;
	localparam logic [2:0] SC_HEX         = 3'd3;
	localparam logic [2:0] SC_AFTER_COLOR = 3'd4;
	localparam logic [2:0] SC_AFTER_COMMA = 3'd5;
	localparam logic [2:0] SC_AFTER_SEMI  = 3'd6;
	localparam logic [2:0] SC_DRAIN       = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_code;
	logic       end_of_text;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] palette_index;
	logic [1:0] slot;
	logic       is_none;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [8:0] palette_count;
	logic [2:0] error_code;
	logic       last_of_run;

	inline_palette_spec_parser_top DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser model state
	logic [2:0]  scan_state;
	int unsigned none_len;
	int unsigned hex_len;
	logic [23:0] hex_acc;
	logic [2:0]  color_pos;
	logic [8:0]  palette_num;

	ipsp_pkg::result_t word_results[$];
	ipsp_pkg::result_t pending_results[$];
	logic [7:0]  spec_text[$];

	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned words_sent = 0;
	int unsigned cycle_count = 0;
	bit          idling;
	bit          long_hold_req;

	string hex_chars = "0123456789ABCDEFabcdef";
	string tricky_chars = "#,;: \tnNoOeEx0fF";
	string sep_chars = ",;:";

	function automatic int hex_digit_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic void clear_parse();
		scan_state = SC_LEAD;
		none_len = 0;
		hex_len = 0;
		hex_acc = '0;
		color_pos = '0;
		palette_num = '0;
	endfunction

	function automatic void add_result(logic [1:0] k, logic nn, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [8:0] count, logic [2:0] code);
		ipsp_pkg::result_t x;
		x = '0;
		x.kind = k;
		if (k == ipsp_pkg::KIND_COLOR) begin
			x.palette_index = palette_num[7:0];
			x.slot = color_pos[1:0];
		end
		x.is_none = nn;
		x.red = r;
		x.green = g;
		x.blue = b;
		x.palette_count = count;
		x.error_code = code;
		word_results.insert(word_results.size(), x);
	endfunction

	// an error at end of text restarts the parser, otherwise the rest of the text is dropped
	function automatic void parse_error(logic [2:0] code, logic eot);
		add_result(ipsp_pkg::KIND_ERROR, 1'b0, '0, '0, '0, '0, code);
		if (eot)
			clear_parse();
		else
			scan_state = SC_DRAIN;
	endfunction

	function automatic void parse_separator(logic [7:0] c, logic eot);
		if (eot) begin
			add_result(ipsp_pkg::KIND_DONE, 1'b0, '0, '0, '0, palette_num + 9'd1, '0);
			clear_parse();
		end else if (c != CH_SPACE && c != CH_TAB) begin
			case (scan_state)
				SC_AFTER_COLOR: begin
					if (c == ",") begin
						color_pos++;
						scan_state = SC_AFTER_COMMA;
					end else if (c == ";" || c == ":") begin
						color_pos = '0;
						scan_state = SC_AFTER_SEMI;
					end else
						parse_error(ipsp_pkg::ERR_BAD_SEP, 1'b0);
				end
				SC_AFTER_COMMA: begin
					if (c == ";" || c == ":") begin
						color_pos = '0;
						scan_state = SC_AFTER_SEMI;
					end else if (color_pos >= 3'd4)
						parse_error(ipsp_pkg::ERR_OVER_FOUR, 1'b0);
					else if (c == CH_HASH)
						scan_state = SC_OPEN;
					else
						parse_error(ipsp_pkg::ERR_EXPECT_HASH, 1'b0);
				end
				default: begin
					// first non-blank after ';' or ':' opens the next palette
					if (palette_num + 9'd1 >= 9'(ipsp_pkg::MAX_PALETTES))
						parse_error(ipsp_pkg::ERR_TOO_MANY_PAL, 1'b0);
					else begin
						palette_num++;
						color_pos = '0;
						if (c == CH_HASH)
							scan_state = SC_OPEN;
						else
							parse_error(ipsp_pkg::ERR_EXPECT_HASH, 1'b0);
					end
				end
			endcase
		end
	endfunction

	function automatic void parse_word(logic [7:0] c, logic eot);
		int d;
		ipsp_pkg::result_t x;
		word_results.delete();
		case (scan_state)
			SC_LEAD: begin
				if (eot)
					parse_error(ipsp_pkg::ERR_MISSING_COLOR, 1'b1);
				else
					scan_state = SC_OPEN;
			end
			SC_OPEN: begin
				d = hex_digit_value(c);
				if (eot)
					parse_error(ipsp_pkg::ERR_MISSING_COLOR, 1'b1);
				else if ((c | 8'h20) == "n") begin
					none_len = 1;
					scan_state = SC_NONE;
				end else if (d >= 0) begin
					hex_len = 1;
					hex_acc = 24'(d);
					scan_state = SC_HEX;
				end else
					parse_error(ipsp_pkg::ERR_MISSING_COLOR, 1'b0);
			end
			SC_NONE: begin
				if (!eot && none_len < 4 && (c | 8'h20) == NONE_WORD[8 * (3 - none_len) +: 8]) begin
					none_len++;
					if (none_len >= 4) begin
						add_result(ipsp_pkg::KIND_COLOR, 1'b1, '0, '0, '0, '0, '0);
						none_len = 0;
						scan_state = SC_AFTER_COLOR;
					end
				end else begin
					none_len = 0;
					parse_error(ipsp_pkg::ERR_MISSING_COLOR, eot);
				end
			end
			SC_HEX: begin
				d = eot ? -1 : hex_digit_value(c);
				if (d >= 0) begin
					hex_acc = {hex_acc[19:0], 4'(d)};
					hex_len++;
					if (hex_len >= 7)
						parse_error(ipsp_pkg::ERR_DIGIT_COUNT, 1'b0);
				end else if (hex_len == 3 || hex_len == 6) begin
					// short form repeats each nibble, i.e. digit * 17
					if (hex_len == 3)
						add_result(ipsp_pkg::KIND_COLOR, 1'b0, {2{hex_acc[11:8]}},
								{2{hex_acc[7:4]}}, {2{hex_acc[3:0]}}, '0, '0);
					else
						add_result(ipsp_pkg::KIND_COLOR, 1'b0, hex_acc[23:16], hex_acc[15:8],
								hex_acc[7:0], '0, '0);
					hex_len = 0;
					hex_acc = '0;
					scan_state = SC_AFTER_COLOR;
					// the character ending the run is also the separator
					parse_separator(c, eot);
				end else
					parse_error(ipsp_pkg::ERR_DIGIT_COUNT, eot);
			end
			SC_AFTER_COLOR, SC_AFTER_COMMA, SC_AFTER_SEMI: parse_separator(c, eot);
			default: begin
				if (eot)
					clear_parse();
			end
		endcase
		foreach (word_results[i]) begin
			x = word_results[i];
			x.last_of_run = (i == word_results.size() - 1);
			pending_results.insert(pending_results.size(), x);
		end
	endfunction

	function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_and_predict
		ipsp_pkg::result_t want;
		ipsp_pkg::result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {kind, palette_index, slot, is_none, red, green, blue, palette_count,
					error_code, last_of_run};
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d: unexpected word, kind %0d", results_seen, got.kind);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("palette_index", want.palette_index, got.palette_index);
				check_field("slot", want.slot, got.slot);
				check_field("is_none", want.is_none, got.is_none);
				check_field("red", want.red, got.red);
				check_field("green", want.green, got.green);
				check_field("blue", want.blue, got.blue);
				check_field("palette_count", want.palette_count, got.palette_count);
				check_field("error_code", want.error_code, got.error_code);
				check_field("last_of_run", want.last_of_run, got.last_of_run);
			end
		end
		if (arst_n && in_valid && in_ready)
			parse_word(char_code, end_of_text);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stall bursts plus an occasional long hold-off
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic send_word(logic [7:0] c, logic eot);
		int gap;
		if (idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		char_code <= c;
		end_of_text <= eot;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_text();
		foreach (spec_text[i])
			send_word(spec_text[i], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic void add_char(logic [7:0] c);
		spec_text.insert(spec_text.size(), c);
	endfunction

	task automatic send_string(string s);
		spec_text.delete();
		foreach (s[i])
			add_char(s[i]);
		send_text();
	endtask

	function automatic void put_blanks();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endfunction

	// 0 means "none"; bad run lengths only when not clean
	function automatic int pick_digits(bit clean);
		int k;
		k = $urandom_range(0, 19);
		if (!clean && k == 0) begin
			case ($urandom_range(0, 4))
				0: return 1;
				1: return 2;
				2: return 4;
				3: return 5;
				default: return 7;
			endcase
		end
		if (k < 6) return 0;
		if (k < 13) return 3;
		return 6;
	endfunction

	function automatic void put_color_body(int digits);
		if (digits == 0) begin
			for (int i = 0; i < 4; i++)
				add_char(NONE_WORD[8 * (3 - i) +: 8] ^
						(($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00));
		end else
			repeat (digits)
				add_char(hex_chars[$urandom_range(0, 21)]);
	endfunction

	function automatic void build_random_text(bit clean);
		int pals;
		int cols;
		int pos;
		spec_text.delete();
		if (!clean && $urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(0, 10))
				add_char(8'($urandom_range(0, 255)));
			return;
		end
		add_char((!clean && $urandom_range(0, 9) == 0) ?
				8'($urandom_range(0, 255)) : CH_HASH);
		pals = $urandom_range(1, 4);
		for (int p = 0; p < pals; p++) begin
			cols = (!clean && $urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
			for (int k = 0; k < cols; k++) begin
				if (p > 0 || k > 0)
					add_char(CH_HASH);
				put_color_body(pick_digits(clean));
				put_blanks();
				if (k < cols - 1) begin
					add_char(",");
					put_blanks();
				end
			end
			if (p < pals - 1) begin
				add_char(sep_chars[$urandom_range(1, 2)]);
				put_blanks();
			end
		end
		if ($urandom_range(0, 2) == 0)
			add_char(sep_chars[$urandom_range(0, 2)]);
		if (!clean && $urandom_range(0, 2) == 0) begin
			pos = $urandom_range(0, spec_text.size() - 1);
			case ($urandom_range(0, 3))
				0: spec_text[pos] = 8'($urandom_range(0, 255));
				1: spec_text.insert(pos, 8'($urandom_range(0, 255)));
				2: spec_text.delete(pos);
				default: spec_text[pos] = tricky_chars[$urandom_range(0, tricky_chars.len() - 1)];
			endcase
		end
	endfunction

	// every palette allowed, one short color each
	function automatic void build_full_palettes();
		spec_text.delete();
		add_char(CH_HASH);
		put_color_body(3);
		for (int p = 1; p < int'(ipsp_pkg::MAX_PALETTES); p++) begin
			add_char(sep_chars[$urandom_range(1, 2)]);
			add_char(CH_HASH);
			put_color_body(3);
		end
	endfunction

	task automatic test_directed();
		idling = 1'b1;
		send_string("");
		send_string("#");
		send_string("#nOnE ,\t#F0a;#0123aB;");
		send_string("#1234567");
	endtask

	task automatic test_palette_limit();
		// one palette too many, rest of the text is dropped
		build_full_palettes();
		add_char(";");
		add_char(CH_HASH);
		add_char("a");
		add_char("b");
		add_char("c");
		send_text();
	endtask

	task automatic test_random_texts();
		int unsigned start;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			idling = ($urandom_range(0, 3) != 0);
			build_random_text(1'b0);
			send_text();
		end
	endtask

	task automatic test_backpressure();
		idling = 1'b0;
		long_hold_req = 1'b1;
		repeat (3) begin
			build_random_text(1'b1);
			send_text();
		end
	endtask

	task automatic test_quiet_tail();
		idling = 1'b0;
		repeat (3) begin
			build_random_text(1'b0);
			send_text();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		end_of_text = 1'b0;
		idling = 1'b1;
		long_hold_req = 1'b0;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_palette_limit();
		test_random_texts();
		test_backpressure();
		test_quiet_tail();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
